// ===== rtl/mhc_pkg.sv =====
// mhc_pkg: shared constants, control codes, angle table and the
// controller-to-datapath command struct of the magnetometer heading block.
// No dependencies.
package mhc_pkg;

  // default configuration
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ANGLE_STEPS_DEF = 16;

  // cordic table length and step index width
  localparam int TABLE_LEN = 24;
  localparam int STEP_W    = 5;

  // angle word: 1/65536 degree, room for a full turn plus margin
  localparam int ZW = 27;
  localparam logic signed [ZW-1:0] DEG_90    = 27'sd5898240;
  localparam logic signed [ZW-1:0] FULL_TURN = 27'sd23592960;

  // heading width and modulus in 1/64 degree
  localparam int HEADING_W = 15;
  localparam int HEADING_MOD = 23040;

  // smoothing weight, about 0.1 in 1/65536
  localparam logic signed [14:0] ALPHA_NUM = 15'sd6554;

  // calibration control codes
  localparam logic [1:0] CTL_OFF  = 2'd0;
  localparam logic [1:0] CTL_ON   = 2'd1;
  localparam logic [1:0] CTL_SAVE = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              capture;
    logic              smooth;
    logic              load;
    logic              iter;
    logic              finish;
    logic [STEP_W-1:0] step;
  } mhc_cmd_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117304;
      5'd6:    v = 27'sd58666;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      5'd22:   v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mhc_ctrl.sv =====
// mhc_ctrl: sequencing state machine of the heading block, output valid flag.
// Depends on mhc_pkg.
module mhc_ctrl
  import mhc_pkg::*;
#(
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output mhc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SMOOTH = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_ITER   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ANGLE_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.step    = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid: set when a result is loaded, cleared when it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/mhc_dp.sv =====
// mhc_dp: smoothing, min/max calibration, offsets, iterative cordic and the
// output payload registers. Driven by commands from mhc_ctrl. Depends on mhc_pkg.
module mhc_dp
  import mhc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mhc_cmd_t                      cmd,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_wr_data,
  input  logic signed [SAMPLE_BITS-1:0] raw_x,
  input  logic signed [SAMPLE_BITS-1:0] raw_y,
  input  logic signed [SAMPLE_BITS-1:0] raw_z,
  output logic [HEADING_W-1:0]          heading,
  output logic signed [SAMPLE_BITS:0]   offset_x_out,
  output logic signed [SAMPLE_BITS:0]   offset_y_out,
  output logic signed [SAMPLE_BITS:0]   offset_z_out,
  output logic                          offsets_saved
);

  localparam int SB = SAMPLE_BITS;
  localparam int SW = SB + 16;   // smoothed q16.16 word
  localparam int DW = SB + 17;   // difference word
  localparam int PW = DW + 15;   // product word
  localparam int CW = SB + 20;   // cordic vector word
  localparam int RW = ZW - 10;   // rounded angle word

  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  logic signed [SB-1:0] raw_r  [3];
  logic signed [SW-1:0] s_r    [3];
  logic signed [SB-1:0] min_r  [3];
  logic signed [SB-1:0] max_r  [3];
  logic signed [SB:0]   off_r  [3];
  logic [1:0]           ctl_r;
  logic [1:0]           prev_r;
  logic                 seen_r;
  logic                 saved_r;

  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic                 zero_r;

  logic [HEADING_W-1:0] heading_r;
  logic signed [SB:0]   out_off_r [3];
  logic                 out_saved_r;

  logic signed [SW-1:0] s_nxt [3];
  logic signed [CW-1:0] vx, vy, lx, ly, xs, ys;
  logic signed [ZW-1:0] lz, zpos;
  logic signed [RW-1:0] rnd, hd;

  // exponential smoothing per axis, s += floor((raw*2^16 - s) * alpha / 2^16)
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [DW-1:0] diff;
      logic signed [PW-1:0] prod;
      diff     = (DW'(raw_r[a]) <<< 16) - DW'(s_r[a]);
      prod     = PW'(diff) * PW'(ALPHA_NUM);
      s_nxt[a] = s_r[a] + SW'(prod >>> 16);
    end
  end

  // offset-corrected vector and quarter turn into the right half plane
  always_comb begin
    vx = CW'(s_r[0]) - (CW'(off_r[0]) <<< 15);
    vy = (CW'(off_r[1]) <<< 15) - CW'(s_r[1]);
    lx = vx;
    ly = vy;
    lz = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        lx = vy;
        ly = -vx;
        lz = DEG_90;
      end else begin
        lx = -vy;
        ly = vx;
        lz = -DEG_90;
      end
    end
  end

  // one micro-rotation's shifted terms
  assign xs = x_r >>> cmd.step;
  assign ys = y_r >>> cmd.step;

  // wrap to a positive angle and round to 1/64 degree
  always_comb begin
    zpos = (z_r < 0) ? z_r + FULL_TURN : z_r;
    rnd  = RW'((zpos + ZW'(512)) >>> 10);
    hd   = (rnd >= RW'(HEADING_MOD)) ? rnd - RW'(HEADING_MOD) : rnd;
    if (hd < 0 || zero_r) begin
      hd = '0;
    end
  end

  // calibration control and state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= CTL_OFF;
      prev_r  <= CTL_OFF;
      seen_r  <= 1'b0;
      saved_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        s_r[a]   <= '0;
        min_r[a] <= SMAX;
        max_r[a] <= SMIN;
        off_r[a] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        ctl_r <= cfg_wr_data;
      end
      if (cmd.smooth) begin
        saved_r <= (ctl_r != prev_r) && (ctl_r == CTL_SAVE);
        prev_r  <= ctl_r;
        for (int a = 0; a < 3; a++) begin
          s_r[a] <= s_nxt[a];
        end
        if (ctl_r != prev_r) begin
          if (ctl_r == CTL_ON) begin
            // entering calibration: restart extremes
            seen_r <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              min_r[a] <= SMAX;
              max_r[a] <= SMIN;
            end
          end else if (ctl_r == CTL_SAVE) begin
            // offsets in half counts, zero if nothing was tracked
            for (int a = 0; a < 3; a++) begin
              off_r[a] <= seen_r ? (SB+1)'(max_r[a]) + (SB+1)'(min_r[a]) : '0;
            end
          end
        end else if (ctl_r == CTL_ON) begin
          // track extremes of the raw samples
          seen_r <= 1'b1;
          for (int a = 0; a < 3; a++) begin
            if (raw_r[a] < min_r[a]) begin
              min_r[a] <= raw_r[a];
            end
            if (raw_r[a] > max_r[a]) begin
              max_r[a] <= raw_r[a];
            end
          end
        end
      end
    end
  end

  // sample capture, cordic registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r[0] <= raw_x;
      raw_r[1] <= raw_y;
      raw_r[2] <= raw_z;
    end
    if (cmd.load) begin
      x_r    <= lx;
      y_r    <= ly;
      z_r    <= lz;
      zero_r <= (vx == 0) && (vy == 0);
    end else if (cmd.iter) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_lut(cmd.step);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_lut(cmd.step);
      end
    end
    if (cmd.finish) begin
      heading_r   <= HEADING_W'(hd);
      out_saved_r <= saved_r;
      for (int a = 0; a < 3; a++) begin
        out_off_r[a] <= off_r[a];
      end
    end
  end

  assign heading       = heading_r;
  assign offset_x_out  = out_off_r[0];
  assign offset_y_out  = out_off_r[1];
  assign offset_z_out  = out_off_r[2];
  assign offsets_saved = out_saved_r;

endmodule

// ===== rtl/magnetometer_heading_calibration.sv =====
// magnetometer_heading_calibration: top level, stream ports and field packing.
// Instantiates mhc_ctrl and mhc_dp; depends on mhc_pkg.
//
// Usage
//   in_*  : one raw three-axis sample per item (x, y, z signed counts).
//   out_* : one result per item: heading in 1/64 degree plus the current
//           hard-iron offsets in half counts; out_tuser flags an item whose
//           step saved new offsets.
//   cfg_* : cal_control, 0 off, 1 track min/max, 2 off and save offsets;
//           write it only while no item is in flight.
// Timing
//   An item is accepted in the idle state, then passes through the smoothing
//   state, the vector load state and one cordic micro-rotation per step; the
//   result is loaded into the output register in the finish state, which
//   waits for that register to be free. No new item is taken until the block
//   is back in idle, as the single shared cordic rotator serves one at a time.
// Reset and stall
//   Reset clears smoothing, offsets and the control to zero, extremes to
//   their sentinels and drops out_tvalid. While out_tready is low the
//   finished result waits in the output register; the next item can still
//   be accepted and computed, and its result waits until that slot frees.
module magnetometer_heading_calibration
  import mhc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF,
  localparam int IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_F = HEADING_W + 3 * (SAMPLE_BITS + 1),
  localparam int OUT_W = ((OUT_F + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // raw_x, raw_y, raw_z, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // heading, offset_x_out, offset_y_out,
                                       // offset_z_out, zero pad
  output logic             out_tuser,  // offsets_saved
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data
);

  localparam int SB = SAMPLE_BITS;

  mhc_cmd_t             cmd;
  logic [HEADING_W-1:0] heading;
  logic signed [SB:0]   off_x, off_y, off_z;
  logic                 saved;

  mhc_ctrl #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  mhc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .raw_x         (in_tdata[SB-1:0]),
    .raw_y         (in_tdata[2*SB-1:SB]),
    .raw_z         (in_tdata[3*SB-1:2*SB]),
    .heading       (heading),
    .offset_x_out  (off_x),
    .offset_y_out  (off_y),
    .offset_z_out  (off_z),
    .offsets_saved (saved)
  );

  // result packing, heading in the low bits
  assign out_tdata = OUT_W'({off_z, off_y, off_x, heading});
  assign out_tuser = saved;

endmodule

// ===== rtl/mhc_checker.sv =====
// mhc_port_checker: port-level assertions for magnetometer_heading_calibration,
// bound to the top level. Depends on mhc_pkg.
module mhc_port_checker
  import mhc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OUT_W = ((HEADING_W + 3 * (SAMPLE_BITS + 1) + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // one item at a time: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // heading stays below a full turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[HEADING_W-1:0] < HEADING_W'(HEADING_MOD))
    else $error("heading out of range");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a result leaves only through a handshake
  a_drop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("result dropped without handshake");

endmodule

bind magnetometer_heading_calibration mhc_port_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mhc_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/mhc_checker.sv =====
`timescale 1ns / 100ps
// mhc_checker: watches the sample, result and control channels of the heading block,
// predicts every result item and compares it field by field with what comes out.
// Depends on mhc_pkg for widths and control codes.
module mhc_checker
  import mhc_pkg::*;
#(
  parameter int IN_W  = 48,
  parameter int OUT_W = 72
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tuser,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  output int               mismatch_count,
  output int               pending_count
);

  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int OW    = SB + 1;
  localparam int STEPS = (ANGLE_STEPS_DEF < TABLE_LEN) ? ANGLE_STEPS_DEF : TABLE_LEN;
  localparam longint ONE_DEG    = 65536;
  localparam longint TURN       = 360 * ONE_DEG;
  localparam longint AXIS_TOP   = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint AXIS_FLOOR = -(64'sd1 <<< (SB - 1));

  typedef struct packed {
    logic [HEADING_W-1:0] heading;
    logic signed [OW-1:0] off_x;
    logic signed [OW-1:0] off_y;
    logic signed [OW-1:0] off_z;
    logic                 saved;
  } heading_result_t;

  // micro-rotation angles atan(2^-i) in 1/65536 degree
  longint arctan_steps [0:TABLE_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // predicted block state
  longint          smooth_acc [3];
  longint          axis_lo    [3];
  longint          axis_hi    [3];
  longint          hard_iron  [3];
  logic [1:0]      ctl_reg;
  logic [1:0]      ctl_prev;
  logic            tracked;
  heading_result_t expected_q [$];

  // extremes back to their sentinels
  function automatic void clear_extremes();
    int a;
    for (a = 0; a < 3; a++) begin
      axis_lo[a] = AXIS_TOP;
      axis_hi[a] = AXIS_FLOOR;
    end
    tracked = 1'b0;
  endfunction

  // atan2(vy, vx) by cordic, in 1/64 degree within one turn
  function automatic logic [HEADING_W-1:0] compass_angle(input longint vx, input longint vy);
    longint x, y, z, t, xs, ys;
    int     i;
    x = vx;
    y = vy;
    z = 0;
    if (x == 0 && y == 0) return '0;
    // quarter turn into the right half plane
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * ONE_DEG;
      end else begin
        x = -y;
        y = t;
        z = -90 * ONE_DEG;
      end
    end
    for (i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += arctan_steps[i];
      end else begin
        x -= ys;
        y += xs;
        z -= arctan_steps[i];
      end
    end
    if (z < 0) z += TURN;
    // round to 1/64 degree, halves up, and wrap a full turn
    z = (z + 512) >>> 10;
    if (z >= HEADING_MOD) z -= HEADING_MOD;
    if (z < 0) z = 0;
    return z[HEADING_W-1:0];
  endfunction

  // one accepted sample: smoothing, calibration control, then heading
  function automatic heading_result_t step_sample(input logic [IN_W-1:0] word);
    heading_result_t r;
    longint          raw [3];
    longint          diff;
    int              a;
    r = '0;
    for (a = 0; a < 3; a++) begin
      raw[a] = longint'($signed(word[a*SB +: SB]));
      diff = raw[a] * ONE_DEG - smooth_acc[a];
      smooth_acc[a] += (diff * longint'(ALPHA_NUM)) >>> 16;
    end
    if (ctl_reg != ctl_prev) begin
      if (ctl_reg == CTL_ON) begin
        clear_extremes();
      end else if (ctl_reg == CTL_SAVE) begin
        for (a = 0; a < 3; a++)
          hard_iron[a] = tracked ? axis_hi[a] + axis_lo[a] : 0;
        r.saved = 1'b1;
      end
    end else if (ctl_reg == CTL_ON) begin
      for (a = 0; a < 3; a++) begin
        if (raw[a] < axis_lo[a]) axis_lo[a] = raw[a];
        if (raw[a] > axis_hi[a]) axis_hi[a] = raw[a];
      end
      tracked = 1'b1;
    end
    ctl_prev = ctl_reg;
    r.heading = compass_angle(smooth_acc[0] - hard_iron[0] * 32768,
                              hard_iron[1] * 32768 - smooth_acc[1]);
    r.off_x = hard_iron[0][OW-1:0];
    r.off_y = hard_iron[1][OW-1:0];
    r.off_z = hard_iron[2][OW-1:0];
    return r;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    heading_result_t got, want;
    int              a;
    if (!rst_n) begin
      for (a = 0; a < 3; a++) begin
        smooth_acc[a] = 0;
        hard_iron[a]  = 0;
      end
      clear_extremes();
      ctl_reg  = CTL_OFF;
      ctl_prev = CTL_OFF;
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) ctl_reg = cfg_wr_data;
      if (in_tvalid && in_tready) expected_q.push_back(step_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        got.heading = out_tdata[HEADING_W-1:0];
        got.off_x   = out_tdata[HEADING_W +: OW];
        got.off_y   = out_tdata[HEADING_W + OW +: OW];
        got.off_z   = out_tdata[HEADING_W + 2*OW +: OW];
        got.saved   = out_tuser;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result item: heading %0d offsets %0d %0d %0d saved %0b",
                     $realtime, got.heading, got.off_x, got.off_y, got.off_z, got.saved);
        end else begin
          want = expected_q.pop_front();
          if (got.heading !== want.heading || got.off_x !== want.off_x ||
              got.off_y !== want.off_y || got.off_z !== want.off_z ||
              got.saved !== want.saved) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected heading %0d offsets %0d %0d %0d saved %0b,",
                       $realtime, want.heading, want.off_x, want.off_y, want.off_z,
                       want.saved,
                       " got heading %0d offsets %0d %0d %0d saved %0b",
                       got.heading, got.off_x, got.off_y, got.off_z, got.saved);
          end
        end
      end
    end
    pending_count = expected_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: clock, reset, sample stimulus, calibration control writes and the verdict for
// magnetometer_heading_calibration. Depends on mhc_pkg, the block and mhc_checker.
module tb;
  import mhc_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int IN_W          = ((3 * SB + 7) / 8) * 8;
  localparam int OUT_W         = ((HEADING_W + 3 * (SB + 1) + 7) / 8) * 8;
  localparam int RANDOM_ITEMS  = 520;
  localparam int PHASE_ITEMS   = 190;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = ANGLE_STEPS_DEF + 24;
  // unused control code, behaves as off
  localparam logic [1:0] CTL_SPARE = 2'd3;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata    = '0;   // raw_x, raw_y, raw_z
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [OUT_W-1:0] out_tdata;          // heading, offset_x, offset_y, offset_z, pad
  logic             out_tuser;          // offsets_saved
  logic             cfg_wr_en   = 1'b0;
  logic [1:0]       cfg_wr_data = CTL_OFF;

  int mismatch_count;
  int pending_count;
  int send_idle    = 38;
  int recv_idle    = 50;
  int items_sent   = 0;
  int stall_cycles = 0;
  int first_random;
  int cx, cy, cz, spread;
  int kind;

  magnetometer_heading_calibration i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_wr_data
  );

  mhc_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) i_checker (.*);

  always #1 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog on cycles without any accepted item or taken result
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one sample item, with random idle cycles ahead of it
  task automatic send_sample(input int x, input int y, input int z);
    @(negedge clk);
    if (items_sent < PHASE_ITEMS) begin
      send_idle = 38;
      recv_idle = 50;
    end else if (items_sent < 2 * PHASE_ITEMS) begin
      send_idle = 50;
      recv_idle = 38;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({z[SB-1:0], y[SB-1:0], x[SB-1:0]});
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // control write once the block has drained
  task automatic write_control(input logic [1:0] code);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly samples around the current field centre, some full-range noise
  function automatic int axis_value(input int centre);
    int v;
    if ($urandom_range(0, 99) < 15)
      v = $urandom;
    else
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    return v;
  endfunction

  task automatic send_burst(input int count);
    repeat (count) send_sample(axis_value(cx), axis_value(cy), axis_value(cz));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state: zero vector, then axis extremes with calibration off
    send_sample(0, 0, 0);
    send_sample(32767, -32768, 0);
    send_sample(-32768, 32767, -32768);
    send_sample(-32768, -32768, 32767);
    send_sample(1, -1, 1);
    write_control(CTL_OFF);
    send_sample(-1, 0, 0);
    // first item after the change to tracking only clears the extremes
    write_control(CTL_ON);
    send_sample(1000, -2000, 300);
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(5, 5, 5);
    write_control(CTL_SAVE);
    send_sample(0, 0, 0);
    send_sample(100, 100, 100);
    // spare code acts as off but still counts as a change
    write_control(CTL_SPARE);
    send_sample(-300, 200, 0);
    // save with nothing tracked gives zero offsets
    write_control(CTL_ON);
    send_sample(7, 7, 7);
    write_control(CTL_SAVE);
    send_sample(7, 7, 7);
    // one tracked sample puts the offsets at their extremes
    write_control(CTL_ON);
    send_sample(0, 0, 0);
    send_sample(32767, -32768, 32767);
    write_control(CTL_SAVE);
    send_sample(32767, -32768, 32767);
    write_control(CTL_SPARE);
    send_sample(-32768, 32767, -32768);

    // random rounds, mostly full calibration cycles
    first_random = items_sent;
    while (items_sent < first_random + RANDOM_ITEMS) begin
      cx = int'($urandom_range(0, 24000)) - 12000;
      cy = int'($urandom_range(0, 24000)) - 12000;
      cz = int'($urandom_range(0, 24000)) - 12000;
      spread = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8000));
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        write_control(CTL_ON);
        send_burst($urandom_range(2, 20));
        write_control(CTL_SAVE);
        send_burst($urandom_range(1, 10));
      end else if (kind == 6) begin
        write_control(CTL_OFF);
        send_burst($urandom_range(1, 10));
      end else if (kind == 7) begin
        write_control(CTL_SPARE);
        send_burst($urandom_range(1, 10));
      end else if (kind == 8) begin
        write_control(CTL_SAVE);
        send_burst($urandom_range(1, 10));
      end else begin
        write_control(CTL_ON);
        send_burst($urandom_range(1, 6));
      end
    end

    // drain and settle
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
